// ===== hw/rtl/tlv_stream_deframer_unit_defines.svh =====
// Assertion macros shared by the identifier-length-value deframer RTL.
// Defining ASSERT_OFF turns every macro into an empty body.
`ifndef TLV_STREAM_DEFRAMER_UNIT_DEFINES_SVH
`define TLV_STREAM_DEFRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check that is disabled while the synchronous reset is low.
`define TLV_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TLV_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TLV_ASSERT_RST(label, clk, rst_n, prop, msg)
`define TLV_ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/tlvdf_pkg.sv =====
// Types and constants for the identifier-length-value deframer.
// No dependencies.
package tlvdf_pkg;

    typedef logic [2:0] t_phase;

    // Parser phases: identifier, short length, escaped long length, payload.
    localparam t_phase PH_ID    = 3'd0;
    localparam t_phase PH_LEN0  = 3'd1;
    localparam t_phase PH_LEN1  = 3'd2;
    localparam t_phase PH_XLEN0 = 3'd3;
    localparam t_phase PH_XLEN1 = 3'd4;
    localparam t_phase PH_XLEN2 = 3'd5;
    localparam t_phase PH_XLEN3 = 3'd6;
    localparam t_phase PH_DATA  = 3'd7;

    // A short length of all ones announces a 32-bit length.
    localparam logic [15:0] SHORT_ESCAPE = 16'hFFFF;

endpackage

// ===== hw/rtl/tlvdf_if.sv =====
// Valid/ready stream interfaces for the deframer input bytes and results.
// No dependencies.
interface tlvdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlvdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_id;
    logic [31:0] packet_length;
    logic        long_form;
    logic        is_last;
    logic        is_empty;

    modport source (
        output valid, output payload_byte, output packet_id, output packet_length,
        output long_form, output is_last, output is_empty, input ready
    );
    modport sink (
        input valid, input payload_byte, input packet_id, input packet_length,
        input long_form, input is_last, input is_empty, output ready
    );
endinterface

// ===== hw/rtl/tlv_stream_deframer_unit.sv =====
// Splits a byte stream of identifier-length-value packets into tagged payload bytes. The
// block takes one byte per cycle unless a waiting result is stalled at the output: each byte
// updates the parser phase and the held header fields, and any result it produces lands in one output
// register, so a new byte is taken in the same cycle that a waiting result is taken. A
// packet is a one-byte identifier and a 16-bit little-endian length; a length of 0xFFFF is
// followed by a 32-bit little-endian length. Header bytes give no result, each payload byte
// gives one, and a zero-length packet gives a single empty marker with is_last set.
// Depends on tlvdf_pkg, tlvdf_if.sv and tlv_stream_deframer_unit_defines.svh.
`include "tlv_stream_deframer_unit_defines.svh"

module tlv_stream_deframer_unit
    import tlvdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tlvdf_in_if.sink           i_rx,
    tlvdf_out_if.source        o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_id, n_id;
    logic [31:0] r_len, n_len;
    logic [31:0] r_left, n_left;
    logic        r_long, n_long;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_id;
    logic [31:0] r_out_len;
    logic        r_out_long;
    logic        r_out_last;
    logic        r_out_empty;

    logic        w_acc;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_empty;
    logic [15:0] w_len16;
    logic [31:0] w_len32;
    logic [7:0]  b;

    assign b      = i_rx.rx_byte;
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_acc  = i_rx.valid && i_rx.ready;
    assign w_len16 = {b, r_len[7:0]};
    assign w_len32 = {b, r_len[23:0]};

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_len   = r_len;
        n_left  = r_left;
        n_long  = r_long;
        w_emit  = 1'b0;
        w_byte  = 8'd0;
        w_last  = 1'b0;
        w_empty = 1'b0;
        case (r_phase)
            PH_ID: begin
                n_id    = b;
                n_phase = PH_LEN0;
            end
            PH_LEN0: begin
                n_len   = {24'd0, b};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                if (w_len16 == SHORT_ESCAPE) begin
                    n_long  = 1'b1;
                    n_len   = 32'd0;
                    n_phase = PH_XLEN0;
                end else begin
                    n_long = 1'b0;
                    n_len  = {16'd0, w_len16};
                    if (w_len16 == 16'd0) begin
                        w_emit  = 1'b1;
                        w_last  = 1'b1;
                        w_empty = 1'b1;
                        n_phase = PH_ID;
                    end else begin
                        n_left  = {16'd0, w_len16};
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_XLEN0: begin
                n_len   = {24'd0, b};
                n_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
                n_len   = {r_len[31:16], b, r_len[7:0]};
                n_phase = PH_XLEN2;
            end
            PH_XLEN2: begin
                n_len   = {r_len[31:24], b, r_len[15:0]};
                n_phase = PH_XLEN3;
            end
            PH_XLEN3: begin
                n_len = w_len32;
                if (w_len32 == 32'd0) begin
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    w_empty = 1'b1;
                    n_phase = PH_ID;
                end else begin
                    n_left  = w_len32;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_left = r_left - 32'd1;
                w_emit = 1'b1;
                w_byte = b;
                if (r_left == 32'd1) begin
                    w_last  = 1'b1;
                    n_phase = PH_ID;
                end
            end
            default: begin
                n_phase = PH_ID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID;
            r_id    <= 8'd0;
            r_len   <= 32'd0;
            r_left  <= 32'd0;
            r_long  <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_left  <= n_left;
            r_long  <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result fields carry the header as it stands after this byte.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_out_byte  <= w_byte;
            r_out_id    <= n_id;
            r_out_len   <= n_len;
            r_out_long  <= n_long;
            r_out_last  <= w_last;
            r_out_empty <= w_empty;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_byte  = r_out_byte;
    assign o_res.packet_id     = r_out_id;
    assign o_res.packet_length = r_out_len;
    assign o_res.long_form     = r_out_long;
    assign o_res.is_last       = r_out_last;
    assign o_res.is_empty      = r_out_empty;

    // The payload phase is only entered with a nonzero count and left when it reaches one.
    `TLV_ASSERT_RST(a_data_left_nonzero, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_left != 32'd0), "payload phase with no bytes left")

    `TLV_ASSERT_RST(a_empty_marker_shape, i_clk, i_rst_n, (o_res.valid && o_res.is_empty) |-> (o_res.is_last && o_res.payload_byte == 8'd0), "malformed empty marker")

    `TLV_ASSERT_RST(a_short_length_range, i_clk, i_rst_n, (o_res.valid && !o_res.long_form) |-> (o_res.packet_length[31:16] == 16'd0), "short-form length exceeds 16 bits")

    `TLV_ASSERT_RST(a_last_returns_to_id, i_clk, i_rst_n, (w_acc && w_emit && w_last) |=> (r_phase == PH_ID), "parser did not return to identifier after packet end")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for tlv_stream_deframer_unit: directed packet table, then random streams.
// Each transaction is predicted in SystemVerilog and checked against the output stream in order.
// Depends on tlvdf_pkg, tlvdf_if.sv and the deframer RTL.
`timescale 1ns / 1ps

module tb;
    import tlvdf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  packet_id;
        logic [31:0] packet_length;
        logic        long_form;
        logic        is_last;
        logic        is_empty;
    } t_frag;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       has_known;
        t_frag      known_res;
    } t_stim_row;

    localparam t_frag NO_RES = '0;

    logic i_clk;
    logic i_rst_n;

    tlvdf_in_if  rx_if ();
    tlvdf_out_if res_if ();

    tlv_stream_deframer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // Header rows carry no result; markers are typed in, payload rows go to the predictor.
    t_stim_row header_table [] = '{
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{8'h00, 8'h00, 32'h0, 1'b0, 1'b1, 1'b1}},
        '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{8'h00, 8'hFF, 32'h0, 1'b1, 1'b1, 1'b1}},
        '{8'hA5, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h5A, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES}
    };

    t_frag       pending_frags [$];
    int unsigned n_errors;
    int unsigned n_accepted;
    int unsigned n_cycles;

    // Predicted parser state.
    t_phase      pr_phase;
    logic [7:0]  pr_id;
    logic [31:0] pr_len;
    logic [31:0] pr_left;
    logic        pr_long;

    bit          tx_busy;
    int unsigned tx_mode_left;

    function automatic bit deframe_predict(input logic [7:0] b, output t_frag r);
        bit got;
        bit len_known;
        got = 1'b0;
        len_known = 1'b0;
        r = '0;
        case (pr_phase)
            PH_ID: begin
                pr_id = b;
                pr_phase = PH_LEN0;
            end
            PH_LEN0: begin
                pr_len = {24'd0, b};
                pr_phase = PH_LEN1;
            end
            PH_LEN1: begin
                pr_len = {16'd0, b, pr_len[7:0]};
                if (pr_len[15:0] == SHORT_ESCAPE) begin
                    pr_long = 1'b1;
                    pr_len = '0;
                    pr_phase = PH_XLEN0;
                end else begin
                    pr_long = 1'b0;
                    len_known = 1'b1;
                end
            end
            PH_XLEN0: begin
                pr_len = {24'd0, b};
                pr_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
                pr_len[15:8] = b;
                pr_phase = PH_XLEN2;
            end
            PH_XLEN2: begin
                pr_len[23:16] = b;
                pr_phase = PH_XLEN3;
            end
            PH_XLEN3: begin
                pr_len[31:24] = b;
                len_known = 1'b1;
            end
            PH_DATA: begin
                pr_left = pr_left - 32'd1;
                r = '{b, pr_id, pr_len, pr_long, (pr_left == 32'd0), 1'b0};
                got = 1'b1;
                if (pr_left == 32'd0) pr_phase = PH_ID;
            end
            default: ;
        endcase
        if (len_known) begin
            if (pr_len == 32'd0) begin
                r = '{8'h00, pr_id, 32'd0, pr_long, 1'b1, 1'b1};
                got = 1'b1;
                pr_phase = PH_ID;
            end else begin
                pr_left = pr_len;
                pr_phase = PH_DATA;
            end
        end
        return got;
    endfunction

    // Drives one byte from the falling edge and holds it until the transaction completes.
    task automatic send_byte(input logic [7:0] b, input bit has_known, input t_frag known);
        int unsigned gap;
        t_frag       pred;
        if (tx_mode_left == 0) begin
            tx_busy = ($urandom_range(0, 9) < 7);
            tx_mode_left = $urandom_range(20, 80);
        end
        tx_mode_left--;
        gap = tx_busy ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge i_clk); while (!rx_if.ready);
        n_accepted++;
        if (deframe_predict(b, pred)) pending_frags.push_back(has_known ? known : pred);
    endtask

    task automatic send_packet(input logic [7:0] id, input logic [31:0] len, input bit long_len,
                               input int unsigned n_body);
        send_byte(id, 1'b0, NO_RES);
        if (long_len) begin
            send_byte(8'hFF, 1'b0, NO_RES);
            send_byte(8'hFF, 1'b0, NO_RES);
            for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8], 1'b0, NO_RES);
        end else begin
            send_byte(len[7:0], 1'b0, NO_RES);
            send_byte(len[15:8], 1'b0, NO_RES);
        end
        for (int unsigned i = 0; i < n_body; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // Random bytes read in whatever phase the parser is in; the upper length byte is kept
    // small so a stray header cannot swallow the rest of the run.
    task automatic send_noise(input int unsigned count);
        logic [7:0] b;
        for (int unsigned i = 0; i < count || pr_phase != PH_ID; i++) begin
            b = (pr_phase == PH_LEN1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
            send_byte(b, 1'b0, NO_RES);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output checker: every completed transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_frag want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_frags.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual id 0x%0h byte 0x%0h",
                         $time, res_if.packet_id, res_if.payload_byte);
                n_errors++;
            end else begin
                want = pending_frags.pop_front();
                check_field("payload_byte", 32'(want.payload_byte), 32'(res_if.payload_byte));
                check_field("packet_id", 32'(want.packet_id), 32'(res_if.packet_id));
                check_field("packet_length", want.packet_length, res_if.packet_length);
                check_field("long_form", 32'(want.long_form), 32'(res_if.long_form));
                check_field("is_last", 32'(want.is_last), 32'(res_if.is_last));
                check_field("is_empty", 32'(want.is_empty), 32'(res_if.is_empty));
            end
        end
    end

    // Result receiver with random stalls, and stretches without any.
    initial begin
        int unsigned gap;
        int unsigned mode_left;
        bit          busy;
        mode_left = 0;
        busy = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (mode_left == 0) begin
                busy = ($urandom_range(0, 9) < 7);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            gap = busy ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned kind;
        n_errors = 0;
        n_accepted = 0;
        n_cycles = 0;
        tx_busy = 1'b0;
        tx_mode_left = 0;
        pr_phase = PH_ID;
        pr_id = '0;
        pr_len = '0;
        pr_left = '0;
        pr_long = 1'b0;
        i_rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (header_table[i])
            send_byte(header_table[i].rx_byte, header_table[i].has_known,
                      header_table[i].known_res);

        // A short length of 0x00FF must not be taken for the escape.
        send_packet(8'($urandom_range(0, 255)), 32'h0000_00FF, 1'b0, 255);

        while (n_accepted < 900) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_packet(8'($urandom_range(0, 255)), 32'd0, 1'b0, 0);
            end else if (kind < 62) begin
                kind = $urandom_range(1, 12);
                send_packet(8'($urandom_range(0, 255)), kind, 1'b0, kind);
            end else if (kind < 80) begin
                kind = $urandom_range(0, 16);
                send_packet(8'($urandom_range(0, 255)), kind, 1'b1, kind);
            end else if (kind < 86) begin
                kind = $urandom_range(13, 48);
                send_packet(8'($urandom_range(0, 255)), kind, 1'b0, kind);
            end else begin
                send_noise($urandom_range(1, 6));
            end
        end

        // A near-maximal long length leaves the parser in the payload phase to the end.
        send_packet(8'($urandom_range(0, 255)), {24'hFFFFFF, 8'($urandom_range(0, 255))}, 1'b1,
                    40);

        @(negedge i_clk);
        rx_if.valid = 1'b0;
        while (pending_frags.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
